// ----- rtl/core/station_table_with_aging_unit_defines.svh -----
// Assertion macros used by the checker of the station table.
`ifndef STATION_TABLE_WITH_AGING_UNIT_DEFINES_SVH
`define STATION_TABLE_WITH_AGING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define STWA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("station table check failed");

// Next-cycle implication, disabled while reset is high.
`define STWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("station table check failed");

`endif

// ----- rtl/core/stwa_pkg.sv -----
package stwa_pkg;

   localparam int MAX_STATIONS = 8;
   localparam int KEY_BITS     = 64;
   localparam int SLOT_W       = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;

   localparam int TIME_W       = 32;
   localparam int OUT_SLOT_W   = 6;
   localparam int OUT_KEY_W    = 64;
   localparam int IN_KEY_W     = 64;

   // request tdata: station_key, now_ms
   localparam int REQ_DATA_W   = 96;
   // response tdata: slot, entry_key, first_seen, last_ping, last_recv,
   // touched, inserted, sender_key
   localparam int RSP_DATA_W   = 232;

   localparam logic [TIME_W-1:0] STALE_LIMIT_RESET = TIME_W'(50 * 1000);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_AGE,
      ST_EMIT
   } fsm_state_type;

   typedef enum logic {
      CMP_OLDER,   // a < b
      CMP_STALE    // (a - b) mod 2^32 > limit
   } cmp_op_type;

endpackage

// ----- rtl/core/stwa_cmp_unit.sv -----
module stwa_cmp_unit
   import stwa_pkg::*;
(
   input  cmp_op_type        op,
   input  logic [TIME_W-1:0] a,
   input  logic [TIME_W-1:0] b,
   input  logic [TIME_W-1:0] limit,
   output logic              flag
);

   logic [TIME_W:0]   diff;

   // one subtractor, borrow gives a < b, low bits give the wrapped age
   assign diff = {1'b0, a} - {1'b0, b};

   always_comb begin
      unique case (op)
         CMP_OLDER: flag = diff[TIME_W];
         CMP_STALE: flag = (diff[TIME_W-1:0] > limit);
         default:   flag = 1'b0;
      endcase
   end

endmodule

// ----- rtl/core/station_table_with_aging_unit.sv -----
// Station table with aging: 8-slot associative table, LRU-style replacement.
// Sequence: scan one slot per cycle (stops on hit), the update, then aging of every slot;
// then the listing visits slots in order, skipping dead ones, and waits out any
// response stall. A new request is taken only back in idle, after the listing:
// the steps run one after another; scan and aging share the single compare/subtract unit.
// Reset (sync): table cleared.
module station_table_with_aging_unit
   import stwa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [63:0] station_key, [95:64] now_ms
   input  logic                  req_tuser,   // [0] is_sender

   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] slot, [69:6] entry_key,
                                              // [101:70] first_seen, [133:102] last_ping,
                                              // [165:134] last_recv, [166] touched,
                                              // [167] inserted, [231:168] sender_key
   output logic                  rsp_tuser,   // [0] entry_valid
   output logic                  rsp_tlast,

   // stale limit register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TIME_W-1:0]     csr_data
);

   // ---------------------------------------------------------------
   // Slot store: flops; pings are read at every slot, other fields at the sequencer's slot index only
   // ---------------------------------------------------------------
   logic [KEY_BITS-1:0] key_ff        [MAX_STATIONS];
   logic [TIME_W-1:0]   first_seen_ff [MAX_STATIONS];
   logic [TIME_W-1:0]   ping_ff       [MAX_STATIONS];
   logic [TIME_W-1:0]   recv_ff       [MAX_STATIONS];
   logic [KEY_BITS-1:0] sender_ff;
   logic [TIME_W-1:0]   stale_limit_ff;

   // request being worked on
   logic [KEY_BITS-1:0] req_key_ff;
   logic [TIME_W-1:0]   req_now_ff;
   logic                req_sender_ff;

   // sequencer
   fsm_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [SLOT_W-1:0]   oldest_ff, oldest_in;
   logic [TIME_W-1:0]   oldest_ping_ff, oldest_ping_in;
   logic [SLOT_W-1:0]   chosen_ff, chosen_in;
   logic                missed_ff, missed_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   // strobes into the store
   logic                req_take;
   logic                upd_en;
   logic                clr_en;
   logic                rsp_load;
   logic                out_free;

   // shared compare unit
   cmp_op_type          cmp_op;
   logic [TIME_W-1:0]   cmp_a;
   logic [TIME_W-1:0]   cmp_b;
   logic                cmp_flag;

   logic [MAX_STATIONS-1:0] live;
   logic                    later_live;
   logic                    last_slot;
   logic                    key_hit;

   stwa_cmp_unit u_cmp (
      .op    (cmp_op),
      .a     (cmp_a),
      .b     (cmp_b),
      .limit (stale_limit_ff),
      .flag  (cmp_flag)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign last_slot  = (idx_ff == SLOT_W'(MAX_STATIONS - 1));
   assign key_hit    = (key_ff[idx_ff] == req_key_ff);

   // liveness is a nonzero last-ping time
   always_comb begin
      later_live = 1'b0;
      for (int j = 0; j < MAX_STATIONS; j++) begin
         live[j] = |ping_ff[j];
         if (live[j] && (SLOT_W'(j) > idx_ff)) begin
            later_live = 1'b1;
         end
      end
   end

   // compare unit: oldest search during scan, age test during aging
   always_comb begin
      if (state_ff == ST_AGE) begin
         cmp_op = CMP_STALE;
         cmp_a  = req_now_ff;
         cmp_b  = ping_ff[idx_ff];
      end else begin
         cmp_op = CMP_OLDER;
         cmp_a  = ping_ff[idx_ff];
         cmp_b  = oldest_ping_ff;
      end
   end

   // next state and strobes
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      oldest_in      = oldest_ff;
      oldest_ping_in = oldest_ping_ff;
      chosen_in      = chosen_ff;
      missed_in      = missed_ff;
      upd_en         = 1'b0;
      clr_en         = 1'b0;
      rsp_load       = 1'b0;
      rsp_data_in    = '0;
      rsp_user_in    = 1'b0;
      rsp_last_in    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in       = ST_SCAN;
               idx_in         = '0;
               oldest_in      = '0;
               oldest_ping_in = ping_ff[0];
            end
         end

         ST_SCAN: begin
            if (cmp_flag) begin
               oldest_in      = idx_ff;
               oldest_ping_in = ping_ff[idx_ff];
            end
            if (key_hit) begin
               chosen_in = idx_ff;
               missed_in = 1'b0;
               state_in  = ST_UPDATE;
            end else if (last_slot) begin
               chosen_in = cmp_flag ? idx_ff : oldest_ff;
               missed_in = 1'b1;
               state_in  = ST_UPDATE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_UPDATE: begin
            upd_en   = 1'b1;
            idx_in   = '0;
            state_in = ST_AGE;
         end

         ST_AGE: begin
            clr_en = cmp_flag;
            if (last_slot) begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_EMIT: begin
            if (live == '0) begin
               // empty table: one marker response
               if (out_free) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = {OUT_KEY_W'(sender_ff), missed_ff, 167'(0)};
                  rsp_user_in = 1'b0;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else if (!live[idx_ff]) begin
               idx_in = idx_ff + 1'b1;
            end else if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = {OUT_KEY_W'(sender_ff),
                              missed_ff,
                              (idx_ff == chosen_ff),
                              recv_ff[idx_ff],
                              ping_ff[idx_ff],
                              first_seen_ff[idx_ff],
                              OUT_KEY_W'(key_ff[idx_ff]),
                              OUT_SLOT_W'(idx_ff)};
               rsp_user_in = 1'b1;
               rsp_last_in = !later_live;
               if (later_live) begin
                  idx_in = idx_ff + 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sequencer payload and request capture
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      oldest_ff      <= oldest_in;
      oldest_ping_ff <= oldest_ping_in;
      chosen_ff      <= chosen_in;
      missed_ff      <= missed_in;
      if (req_take) begin
         req_key_ff    <= req_tdata[KEY_BITS-1:0];
         req_now_ff    <= req_tdata[IN_KEY_W +: TIME_W];
         req_sender_ff <= req_tuser;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // slot store, stale limit and current sender; store and sender cleared at reset, limit set to its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_STATIONS; i++) begin
            key_ff[i]        <= '0;
            first_seen_ff[i] <= '0;
            ping_ff[i]       <= '0;
            recv_ff[i]       <= '0;
         end
         sender_ff      <= '0;
         stale_limit_ff <= STALE_LIMIT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            stale_limit_ff <= csr_data;
         end
         if (upd_en) begin
            if (missed_ff) begin
               key_ff[chosen_ff]        <= req_key_ff;
               first_seen_ff[chosen_ff] <= req_now_ff;
            end
            ping_ff[chosen_ff] <= req_now_ff;
            if (req_sender_ff) begin
               recv_ff[chosen_ff] <= req_now_ff;
               sender_ff          <= req_key_ff;
            end
         end
         if (clr_en) begin
            key_ff[idx_ff]        <= '0;
            first_seen_ff[idx_ff] <= '0;
            ping_ff[idx_ff]       <= '0;
            recv_ff[idx_ff]       <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/core/stwa_checker.sv -----
`include "station_table_with_aging_unit_defines.svh"

module stwa_checker
   import stwa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   // marker response closes the list
   `STWA_ASSERT_NOW(a_marker_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast)

   // marker response carries no slot contents and no touched flag
   `STWA_ASSERT_NOW(a_marker_empty, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[166:0] == '0)

   // a listed slot is live
   `STWA_ASSERT_NOW(a_listed_live, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[133:102] != '0)

   // busy scanning right after a request is taken
   `STWA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // stalled response holds
   `STWA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind station_table_with_aging_unit stwa_checker u_stwa_checker (.*);

// ----- tb/station_table_with_aging_checker.sv -----
module station_table_with_aging_checker
   import stwa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [TIME_W-1:0]     csr_data,
   output int                    fail_count,
   output int                    rows_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [IN_KEY_W-1:0] KEY_MASK =
      (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);

   typedef struct packed {
      logic [OUT_SLOT_W-1:0] slot;
      logic [OUT_KEY_W-1:0]  entry_key;
      logic [TIME_W-1:0]     first_seen;
      logic [TIME_W-1:0]     last_ping;
      logic [TIME_W-1:0]     last_recv;
      logic                  touched;
      logic                  inserted;
      logic                  entry_valid;
      logic [OUT_KEY_W-1:0]  sender_key;
      logic                  last;
   } station_row_type;

   // shadow copy of the station table
   logic [OUT_KEY_W-1:0] slot_key        [MAX_STATIONS];
   logic [TIME_W-1:0]    slot_first_seen [MAX_STATIONS];
   logic [TIME_W-1:0]    slot_ping       [MAX_STATIONS];
   logic [TIME_W-1:0]    slot_recv       [MAX_STATIONS];
   logic [OUT_KEY_W-1:0] current_sender;
   logic [TIME_W-1:0]    stale_limit;

   station_row_type expected_rows[$];
   int              errors = 0;

   function automatic string describe_row(station_row_type r);
      return $sformatf({"slot=%0d key=%h first=%h ping=%h recv=%h touched=%b ",
                        "inserted=%b valid=%b sender=%h last=%b"},
                       r.slot, r.entry_key, r.first_seen, r.last_ping, r.last_recv,
                       r.touched, r.inserted, r.entry_valid, r.sender_key, r.last);
   endfunction

   // Lookup / replace / age the table for one request, then queue its listing.
   task automatic refresh_station_table(input logic [IN_KEY_W-1:0] raw_key,
                                        input logic [TIME_W-1:0]   now_ms,
                                        input logic                sender);
      logic [OUT_KEY_W-1:0] key;
      logic [TIME_W-1:0]    age;
      logic                 missed;
      int                   i, oldest, hit, chosen, live, listed;
      station_row_type      row;
      key    = raw_key & KEY_MASK;
      oldest = 0;
      hit    = -1;
      // oldest tracks only the slots scanned up to and including the hit
      for (i = 0; i < MAX_STATIONS && hit < 0; i++) begin
         if (slot_ping[i] < slot_ping[oldest]) oldest = i;
         if (slot_key[i] == key) hit = i;
      end
      missed = (hit < 0);
      chosen = missed ? oldest : hit;
      if (missed) begin
         slot_first_seen[chosen] = now_ms;
         slot_key[chosen]        = key;
      end
      slot_ping[chosen] = now_ms;
      if (sender) begin
         slot_recv[chosen] = now_ms;
         current_sender    = key;
      end
      for (i = 0; i < MAX_STATIONS; i++) begin
         age = now_ms - slot_ping[i];
         if (age > stale_limit) begin
            slot_key[i]        = '0;
            slot_first_seen[i] = '0;
            slot_ping[i]       = '0;
            slot_recv[i]       = '0;
         end
      end
      live = 0;
      for (i = 0; i < MAX_STATIONS; i++)
         if (slot_ping[i] != '0) live++;
      listed = 0;
      for (i = 0; i < MAX_STATIONS; i++) begin
         if (slot_ping[i] != '0) begin
            listed++;
            row.slot        = OUT_SLOT_W'(i);
            row.entry_key   = slot_key[i];
            row.first_seen  = slot_first_seen[i];
            row.last_ping   = slot_ping[i];
            row.last_recv   = slot_recv[i];
            row.touched     = (i == chosen);
            row.inserted    = missed;
            row.entry_valid = 1'b1;
            row.sender_key  = current_sender;
            row.last        = (listed == live);
            expected_rows.push_back(row);
         end
      end
      if (live == 0) begin
         // empty table: single marker
         row            = '0;
         row.inserted   = missed;
         row.sender_key = current_sender;
         row.last       = 1'b1;
         expected_rows.push_back(row);
      end
   endtask

   always @(posedge clock) begin
      station_row_type got, want;
      string           bad;
      if (reset) begin
         for (int i = 0; i < MAX_STATIONS; i++) begin
            slot_key[i]        = '0;
            slot_first_seen[i] = '0;
            slot_ping[i]       = '0;
            slot_recv[i]       = '0;
         end
         current_sender = '0;
         stale_limit    = STALE_LIMIT_RESET;
         expected_rows.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.slot        = rsp_tdata[5:0];
            got.entry_key   = rsp_tdata[69:6];
            got.first_seen  = rsp_tdata[101:70];
            got.last_ping   = rsp_tdata[133:102];
            got.last_recv   = rsp_tdata[165:134];
            got.touched     = rsp_tdata[166];
            got.inserted    = rsp_tdata[167];
            got.sender_key  = rsp_tdata[231:168];
            got.entry_valid = rsp_tuser;
            got.last        = rsp_tlast;
            if (expected_rows.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with no request pending: %s",
                           $realtime, describe_row(got));
            end else begin
               want = expected_rows.pop_front();
               bad  = "";
               if (got.slot        !== want.slot)        bad = {bad, " slot"};
               if (got.entry_key   !== want.entry_key)   bad = {bad, " entry_key"};
               if (got.first_seen  !== want.first_seen)  bad = {bad, " first_seen"};
               if (got.last_ping   !== want.last_ping)   bad = {bad, " last_ping"};
               if (got.last_recv   !== want.last_recv)   bad = {bad, " last_recv"};
               if (got.touched     !== want.touched)     bad = {bad, " touched"};
               if (got.inserted    !== want.inserted)    bad = {bad, " inserted"};
               if (got.entry_valid !== want.entry_valid) bad = {bad, " entry_valid"};
               if (got.sender_key  !== want.sender_key)  bad = {bad, " sender_key"};
               if (got.last        !== want.last)        bad = {bad, " last"};
               if (bad != "") begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch on%s\n   expected %s\n   actual   %s",
                              $realtime, bad, describe_row(want), describe_row(got));
               end
            end
         end
         if (csr_valid && csr_ready) stale_limit = csr_data;
         if (req_tvalid && req_tready)
            refresh_station_table(req_tdata[63:0], req_tdata[95:64], req_tuser);
      end
      fail_count   <= errors;
      rows_pending <= expected_rows.size();
   end

endmodule

// ----- tb/station_table_with_aging_unit_tb.sv -----
module station_table_with_aging_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stwa_pkg::*;

   // consecutive cycles with no handshake on any channel before giving up;
   // a correct run never gets near this
   localparam int QUIET_LIMIT = 2000;
   localparam int POOL_SIZE   = 12;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [63:0] station_key, [95:64] now_ms
   logic                  req_tuser  = 1'b0; // [0] is_sender
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [5:0] slot, [69:6] entry_key,
                                             // [101:70] first_seen, [133:102] last_ping,
                                             // [165:134] last_recv, [166] touched,
                                             // [167] inserted, [231:168] sender_key
   logic                  rsp_tuser;         // [0] entry_valid
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [TIME_W-1:0]     csr_data   = '0;

   int fail_count;
   int rows_pending;

   // idling knobs in percent (sender: of requests, receiver: of cycles)
   int sender_idle_pct = 0;
   int rx_stall_pct    = 0;
   int quiet_cycles    = 0;

   // a small set of station keys so that hits, misses and replacement all occur
   logic [OUT_KEY_W-1:0] key_pool [POOL_SIZE];
   logic [TIME_W-1:0]    station_time;

   station_table_with_aging_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   station_table_with_aging_checker u_table_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .rows_pending (rows_pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver backpressure: one draw per cycle, single update per time step.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_stall_pct);

   // Watchdog: any handshake restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request; entered and left at a falling edge. tvalid is only
   // dropped to idle here or in drain_listings, so back-to-back requests keep it high.
   task automatic send_ping(input logic [OUT_KEY_W-1:0] key,
                            input logic [TIME_W-1:0]    now_ms,
                            input logic                 sender);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         // gap long enough to land anywhere in the block's scan/age/list cycle
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {now_ms, key};
      req_tuser  = sender;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold the request channel off until every queued listing row has come back.
   task automatic drain_listings();
      req_tvalid = 1'b0;
      while (rows_pending != 0) @(negedge clock);
   endtask

   task automatic write_stale_limit(input logic [TIME_W-1:0] limit);
      csr_valid = 1'b1;
      csr_data  = limit;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Mostly keys from the pool, some zero / all-ones keys, some fresh noise.
   function automatic logic [OUT_KEY_W-1:0] pick_station_key();
      int r;
      r = $urandom_range(99);
      if (r < 70) return key_pool[$urandom_range(POOL_SIZE - 1)];
      if (r < 80) return '0;
      if (r < 85) return '1;
      return {$urandom, $urandom};
   endfunction

   initial begin
      int                phase, n, r, items;
      logic [TIME_W-1:0] limit, step;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part, reset stale limit (50000), no idling ----
      // zero key matches empty slot 0; touched at time 0 -> not live, marker row
      send_ping('0, 32'd0, 1'b0);
      // new key lands in slot 0 at time 0: still marker, but inserted and sender set
      send_ping(key_pool[0], 32'd0, 1'b1);
      send_ping(key_pool[0], 32'd10, 1'b0);
      // all-ones key, sender; replaces the first slot with the lowest ping
      send_ping('1, 32'd20, 1'b1);
      // zero key hits the first empty slot (key 0) instead of inserting
      send_ping('0, 32'd30, 1'b0);
      // fill the remaining slots, alternating sender flag
      for (int i = 1; i <= 5; i++)
         send_ping(key_pool[i], TIME_W'(30 + 10 * i), i[0]);
      // table full: misses evict the least recently pinged slot; a non-sender
      // replacement keeps the evicted slot's receive time
      send_ping(key_pool[6], 32'd90, 1'b0);
      send_ping(key_pool[7], 32'd100, 1'b0);
      send_ping(key_pool[8], 32'd110, 1'b1);
      // jump near the top of the time range: everything else goes stale
      send_ping(key_pool[3], 32'hFFFF_FFF0, 1'b0);
      send_ping(key_pool[3], 32'hFFFF_FFFF, 1'b1);
      // time wraps: age is taken modulo 2^32, so the entry above stays live
      send_ping(key_pool[9], 32'd5, 1'b0);
      send_ping(key_pool[9], 32'd200000, 1'b0);
      // re-ping at time 0: the entry survives but is hidden from the listing
      send_ping(key_pool[9], 32'd0, 1'b0);
      send_ping(key_pool[9], 32'd300, 1'b1);
      station_time = 32'd300;

      // ---- random part: stale limit and idling change per phase ----
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               limit = 32'd1;          items = 10;
               sender_idle_pct = 0;    rx_stall_pct = 0;
            end
            1: begin
               limit = 32'hFFFF_FFFF;  items = 15;
               sender_idle_pct = 69;   rx_stall_pct = 0;
            end
            2: begin
               limit = 32'd3000;       items = 25;
               sender_idle_pct = 0;    rx_stall_pct = 69;
            end
            3: begin
               // zero limit: only entries pinged at the current time survive
               limit = 32'd0;          items = 8;
               sender_idle_pct = 19;   rx_stall_pct = 19;
            end
            4: begin
               limit = STALE_LIMIT_RESET; items = 15;
               sender_idle_pct = 0;    rx_stall_pct = 0;
            end
            default: begin
               limit = 32'd20000;      items = 18;
               sender_idle_pct = 19;   rx_stall_pct = 19;
            end
         endcase
         // register writes only with the block idle
         drain_listings();
         write_stale_limit(limit);
         for (n = 0; n < items; n++) begin
            // once, mid-phase, the sender waits for all listings to come back
            if (phase == 2 && n == 12) drain_listings();
            r = $urandom_range(99);
            if (r < 10)      step = '0;
            else if (r < 60) step = $urandom_range(1, 2000);
            else if (r < 85) step = $urandom_range(2000, 60000);
            else if (r < 95) step = $urandom_range(60000, 1 << 20);
            else             step = $urandom;
            station_time = station_time + step;
            if ($urandom_range(99) < 3) station_time = '0;
            send_ping(pick_station_key(), station_time, $urandom_range(99) < 30);
         end
      end

      drain_listings();
      // let any stray trailing response show up before the verdict
      repeat (40) @(posedge clock);
      if (fail_count == 0 && rows_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
